### sv/atom_distance_angle_engine_defines.svh
// ============================================================================
// Assertion macros for the atom distance and angle engine
// Concurrent checks that vanish when SYNTH is defined.
// ============================================================================
`ifndef ATOM_DISTANCE_ANGLE_ENGINE_DEFINES_SVH
`define ATOM_DISTANCE_ANGLE_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, clocked on clk and quiet during reset.
`define ADA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ada check failed");
// Next-cycle implication, clocked on clk and quiet during reset.
`define ADA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ada check failed");
`else
`define ADA_ASSERT_IMP(name, ante, cons)
`define ADA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### sv/ada_pkg.sv
// ============================================================================
// ada_pkg
// Shared widths, codes and the CORDIC arc tangent table.
// ============================================================================
package ada_pkg;

    // Table geometry and coordinate format.
    localparam int MAX_ATOMS  = 64;
    localparam int ATOM_IDX_W = $clog2(MAX_ATOMS);
    localparam int COORD_W    = 24;
    localparam int WORD_W     = 3 * COORD_W;
    localparam int COUNT_W    = 7;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_ATOM_COUNT = 3'd0;

    // Command codes.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_DIST  = 2'd1;
    localparam logic [1:0] CMD_ANGLE = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_ZERO_LEN = 2'd2;

    // Result value width.
    localparam int VALUE_W = 25;

    // Square root unit: radicand up to 2^60, root up to 2^30.
    localparam int SQ_IN_W  = 61;
    localparam int SQ_OUT_W = 31;
    localparam logic [SQ_IN_W-1:0] SQ_TOP_BIT  = 61'(1) << 60;
    localparam logic [SQ_IN_W-1:0] COS_ONE_SQ  = 61'(1) << 60;

    // Cosine divider: Q30 result.
    localparam int DIV_W    = 50;
    localparam int COS_FRAC = 30;
    localparam int COS_W    = COS_FRAC + 1;
    localparam logic [COS_W-1:0] COS_ONE = 31'(1) << COS_FRAC;

    // CORDIC rotation.
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int Z_W          = 27;
    localparam logic signed [Z_W-1:0] ANGLE_Q24_PI = 27'sd52707179;

    // Arc tangent of 2^-k in Q24 radians.
    function automatic logic [23:0] ada_atan(input logic [4:0] k);
        logic [23:0] a;
        case (k)
            5'd0:    a = 24'd13176795;
            5'd1:    a = 24'd7778716;
            5'd2:    a = 24'd4110060;
            5'd3:    a = 24'd2086331;
            5'd4:    a = 24'd1047214;
            5'd5:    a = 24'd524117;
            5'd6:    a = 24'd262123;
            5'd7:    a = 24'd131069;
            5'd8:    a = 24'd65536;
            5'd9:    a = 24'd32768;
            5'd10:   a = 24'd16384;
            5'd11:   a = 24'd8192;
            5'd12:   a = 24'd4096;
            5'd13:   a = 24'd2048;
            5'd14:   a = 24'd1024;
            5'd15:   a = 24'd512;
            5'd16:   a = 24'd256;
            5'd17:   a = 24'd128;
            5'd18:   a = 24'd64;
            5'd19:   a = 24'd32;
            5'd20:   a = 24'd16;
            5'd21:   a = 24'd8;
            5'd22:   a = 24'd4;
            5'd23:   a = 24'd2;
            default: a = 24'd0;
        endcase
        return a;
    endfunction

endpackage

### sv/atom_distance_angle_engine.sv
// ============================================================================
// atom_distance_angle_engine
// Atom coordinate table with distance and bond-angle queries.
// ============================================================================
// Usage: an input word carries a command and atom indices. A write stores
// x, y, z of one atom and gives no output word. A distance query gives the
// rounded distance between two atoms; an angle query gives the bond angle at
// the vertex atom in Q2.16 radians. Out-of-range indices give status 1, a
// zero-length bond in an angle query status 2, both with value 0.
// The input channel is stalled while a query is in work, so one item is
// handled at a time. A write is stored without leaving the idle state. A
// query with a bad index goes straight to the done state. The serial
// square root unit (used once for a distance, three times for an angle),
// the cosine divider and the 24-step CORDIC loop set a query's run time.
// The output word sits in a register; a stalled receiver holds it, and the
// engine may accept and work on the next item meanwhile, waiting only to
// hand over its own result. Reset empties the output register and sets
// atom_count to 64. The coordinate table is not cleared: read only entries
// that have been written. atom_count is written over the APB port at address
// 0; the user must change it only while the engine is idle (not enforced).
// ============================================================================
`include "atom_distance_angle_engine_defines.svh"

module atom_distance_angle_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ada_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         cmd,
    input  logic [ada_pkg::ATOM_IDX_W-1:0]      atom_a,
    input  logic [ada_pkg::ATOM_IDX_W-1:0]      atom_b,
    input  logic [ada_pkg::ATOM_IDX_W-1:0]      atom_c,
    input  logic signed [ada_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [ada_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [ada_pkg::COORD_W-1:0]  coord_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ada_pkg::VALUE_W-1:0]         value,
    output logic [1:0]                         status
);
    import ada_pkg::*;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 25'd29058991;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_LDB  = 14'b00000000000010,
        ST_LDA  = 14'b00000000000100,
        ST_LDC  = 14'b00000000001000,
        ST_MUL  = 14'b00000000010000,
        ST_CHK  = 14'b00000000100000,
        ST_SQU  = 14'b00000001000000,
        ST_SQV  = 14'b00000010000000,
        ST_PMUL = 14'b00000100000000,
        ST_DIV  = 14'b00001000000000,
        ST_CSQ  = 14'b00010000000000,
        ST_SIN  = 14'b00100000000000,
        ST_ROT  = 14'b01000000000000,
        ST_DONE = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]     atom_count_reg;
    logic [COUNT_W-1:0]     limit;
    logic                   cfg_wr;
    logic                   accept;
    logic                   a_ok, b_ok, c_ok;
    logic                   load_out;

    logic [ATOM_IDX_W-1:0]  idx_a_reg;
    logic [ATOM_IDX_W-1:0]  idx_c_reg;
    logic                   is_angle_reg;
    logic [ATOM_IDX_W-1:0]  raddr;
    logic                   ram_we;
    logic [WORD_W-1:0]      rd_word;
    logic [WORD_W-1:0]      b_word_reg;
    logic signed [COORD_W:0] dx, dy, dz;
    logic signed [COORD_W:0] u0_reg, u1_reg, u2_reg;
    logic signed [COORD_W:0] v0_reg, v1_reg, v2_reg;

    logic [3:0]             mul_cnt_reg;
    logic [3:0]             acc_idx;
    logic signed [31:0]     mul_a, mul_b;
    logic signed [63:0]     prod_reg;
    logic [DIV_W-1:0]       nu_reg, nv_reg;
    logic signed [51:0]     dot_reg;
    logic [51:0]            dot_abs;
    logic [SQ_OUT_W-1:0]    d1_reg;
    logic [COS_W-1:0]       cos_reg;

    logic                   sq_start, sq_done;
    logic [SQ_IN_W-1:0]     sq_radicand;
    logic [SQ_OUT_W-1:0]    sq_root;
    logic                   div_start, div_done;
    logic [COS_W-1:0]       div_cos;
    logic                   cor_start, cor_done;
    logic [VALUE_W-1:0]     cor_angle;

    logic [VALUE_W-1:0]     res_value_reg;
    logic [1:0]             res_status_reg;
    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [1:0]             status_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr == ADDR_ATOM_COUNT) ? {25'd0, atom_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_count_reg <= 7'(MAX_ATOMS);
        end
        else if (cfg_wr && (paddr == ADDR_ATOM_COUNT))
        begin
            atom_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Index range checks against the effective atom limit.
    assign limit  = (atom_count_reg < 7'(MAX_ATOMS)) ? atom_count_reg : 7'(MAX_ATOMS);
    assign a_ok   = ({1'b0, atom_a} < limit);
    assign b_ok   = ({1'b0, atom_b} < limit);
    assign c_ok   = ({1'b0, atom_c} < limit);
    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid & ~in_stall;
    assign ram_we = accept && (cmd == CMD_WRITE) && a_ok;

    // Read address follows the load sequence: vertex, first, third atom.
    always_comb
    begin
        case (state_reg)
            ST_LDB:  raddr = idx_a_reg;
            ST_LDA:  raddr = idx_c_reg;
            default: raddr = atom_b;
        endcase
    end

    ada_coord_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (atom_a),
        .wdata ({coord_x, coord_y, coord_z}),
        .raddr (raddr),
        .rdata (rd_word)
    );

    // Coordinate differences against the vertex atom.
    assign dx = $signed({rd_word[3*COORD_W-1], rd_word[3*COORD_W-1:2*COORD_W]})
              - $signed({b_word_reg[3*COORD_W-1], b_word_reg[3*COORD_W-1:2*COORD_W]});
    assign dy = $signed({rd_word[2*COORD_W-1], rd_word[2*COORD_W-1:COORD_W]})
              - $signed({b_word_reg[2*COORD_W-1], b_word_reg[2*COORD_W-1:COORD_W]});
    assign dz = $signed({rd_word[COORD_W-1], rd_word[COORD_W-1:0]})
              - $signed({b_word_reg[COORD_W-1], b_word_reg[COORD_W-1:0]});

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                case (mul_cnt_reg)
                    4'd0:    begin mul_a = 32'(u0_reg); mul_b = 32'(u0_reg); end
                    4'd1:    begin mul_a = 32'(u1_reg); mul_b = 32'(u1_reg); end
                    4'd2:    begin mul_a = 32'(u2_reg); mul_b = 32'(u2_reg); end
                    4'd3:    begin mul_a = 32'(v0_reg); mul_b = 32'(v0_reg); end
                    4'd4:    begin mul_a = 32'(v1_reg); mul_b = 32'(v1_reg); end
                    4'd5:    begin mul_a = 32'(v2_reg); mul_b = 32'(v2_reg); end
                    4'd6:    begin mul_a = 32'(u0_reg); mul_b = 32'(v0_reg); end
                    4'd7:    begin mul_a = 32'(u1_reg); mul_b = 32'(v1_reg); end
                    4'd8:    begin mul_a = 32'(u2_reg); mul_b = 32'(v2_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_SQV:
            begin
                mul_a = $signed({1'b0, d1_reg});
                mul_b = $signed({1'b0, sq_root});
            end
            ST_DIV:
            begin
                mul_a = $signed({1'b0, div_cos});
                mul_b = $signed({1'b0, div_cos});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_idx = mul_cnt_reg - 4'd1;
    assign dot_abs = dot_reg[51] ? 52'(-dot_reg) : 52'(dot_reg);

    // Unit starts and the square root operand.
    assign sq_start  = (state_reg == ST_CHK && !(is_angle_reg && (nu_reg == '0 || nv_reg == '0)))
                     || (state_reg == ST_SQU && sq_done && is_angle_reg)
                     || (state_reg == ST_CSQ);
    assign div_start = (state_reg == ST_PMUL);
    assign cor_start = (state_reg == ST_SIN) && sq_done;

    always_comb
    begin
        case (state_reg)
            ST_SQU:  sq_radicand = 61'(nv_reg);
            ST_CSQ:  sq_radicand = COS_ONE_SQ - prod_reg[SQ_IN_W-1:0];
            default: sq_radicand = 61'(nu_reg);
        endcase
    end

    ada_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_radicand),
        .done     (sq_done),
        .root     (sq_root)
    );

    ada_cos_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mag     (dot_abs[DIV_W-1:0]),
        .divisor (prod_reg[DIV_W-1:0]),
        .done    (div_done),
        .cos_q   (div_cos)
    );

    ada_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .cos_in (cos_reg),
        .sin_in (sq_root),
        .obtuse (dot_reg[51]),
        .done   (cor_done),
        .angle  (cor_angle)
    );

    // Sequencer.
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_DIST:  state_next = (a_ok && b_ok) ? ST_LDB : ST_DONE;
                        CMD_ANGLE: state_next = (a_ok && b_ok && c_ok) ? ST_LDB : ST_DONE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LDB:  state_next = ST_LDA;
            ST_LDA:  state_next = is_angle_reg ? ST_LDC : ST_MUL;
            ST_LDC:  state_next = ST_MUL;
            ST_MUL:
            begin
                if ((!is_angle_reg && mul_cnt_reg == 4'd3) || mul_cnt_reg == 4'd9)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:  state_next = sq_start ? ST_SQU : ST_DONE;
            ST_SQU:
            begin
                if (sq_done)
                begin
                    state_next = is_angle_reg ? ST_SQV : ST_DONE;
                end
            end
            ST_SQV:  state_next = sq_done ? ST_PMUL : ST_SQV;
            ST_PMUL: state_next = ST_DIV;
            ST_DIV:  state_next = div_done ? ST_CSQ : ST_DIV;
            ST_CSQ:  state_next = ST_SIN;
            ST_SIN:  state_next = sq_done ? ST_ROT : ST_SIN;
            ST_ROT:  state_next = cor_done ? ST_DONE : ST_ROT;
            ST_DONE: state_next = load_out ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mul_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_MUL)
            begin
                mul_cnt_reg <= mul_cnt_reg + 4'd1;
            end
            else
            begin
                mul_cnt_reg <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                idx_a_reg    <= atom_a;
                idx_c_reg    <= atom_c;
                is_angle_reg <= (cmd == CMD_ANGLE);
                res_value_reg  <= '0;
                res_status_reg <= STAT_RANGE;
            end
            ST_LDB:
            begin
                b_word_reg <= rd_word;
                nu_reg     <= '0;
                nv_reg     <= '0;
                dot_reg    <= '0;
            end
            ST_LDA:
            begin
                u0_reg <= dx;
                u1_reg <= dy;
                u2_reg <= dz;
            end
            ST_LDC:
            begin
                v0_reg <= dx;
                v1_reg <= dy;
                v2_reg <= dz;
            end
            ST_MUL:
            begin
                if (mul_cnt_reg != 4'd0)
                begin
                    case (acc_idx) inside
                        [4'd0:4'd2]: nu_reg  <= nu_reg + prod_reg[DIV_W-1:0];
                        [4'd3:4'd5]: nv_reg  <= nv_reg + prod_reg[DIV_W-1:0];
                        [4'd6:4'd8]: dot_reg <= dot_reg + prod_reg[51:0];
                        default:     dot_reg <= dot_reg;
                    endcase
                end
            end
            ST_CHK:
            begin
                res_value_reg  <= '0;
                res_status_reg <= STAT_ZERO_LEN;
            end
            ST_SQU:
            begin
                d1_reg         <= sq_root;
                res_value_reg  <= sq_root[VALUE_W-1:0];
                res_status_reg <= STAT_OK;
            end
            ST_DIV:
            begin
                cos_reg <= div_cos;
            end
            ST_ROT:
            begin
                res_value_reg  <= cor_angle;
                res_status_reg <= STAT_OK;
            end
            default:
            begin
                cos_reg <= cos_reg;
            end
        endcase
        if (load_out)
        begin
            value_reg  <= res_value_reg;
            status_reg <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // Checks.
    `ADA_ASSERT_NEXT(a_write_stays_idle, in_valid && !in_stall && cmd == CMD_WRITE, state_reg == ST_IDLE)
    `ADA_ASSERT_NEXT(a_done_shows_word, state_reg == ST_DONE, out_valid)
    `ADA_ASSERT_IMP(a_cos_bound, div_done, div_cos <= COS_ONE)
    `ADA_ASSERT_IMP(a_value_bound, out_valid && status == STAT_OK, value <= VALUE_MAX)

endmodule

### sv/ada_coord_ram.sv
// ============================================================================
// ada_coord_ram
// Coordinate table: one write port, one read port with registered data.
// ============================================================================
module ada_coord_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ada_pkg::ATOM_IDX_W-1:0] waddr,
    input  logic [ada_pkg::WORD_W-1:0]     wdata,
    input  logic [ada_pkg::ATOM_IDX_W-1:0] raddr,
    output logic [ada_pkg::WORD_W-1:0]     rdata
);
    import ada_pkg::*;

    logic [WORD_W-1:0] mem [0:MAX_ATOMS-1];
    logic [WORD_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/ada_isqrt.sv
// ============================================================================
// ada_isqrt
// Rounded integer square root, one result bit per cycle.
// ============================================================================
module ada_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ada_pkg::SQ_IN_W-1:0]  radicand,
    output logic                        done,
    output logic [ada_pkg::SQ_OUT_W-1:0] root
);
    import ada_pkg::*;

    logic [SQ_IN_W-1:0]  rem_reg;
    logic [SQ_IN_W-1:0]  bit_reg;
    logic [SQ_IN_W:0]    r_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic                run_reg;
    logic                rnd_reg;
    logic                done_reg;
    logic [SQ_IN_W:0]    trial;
    logic                take;

    // Trial subtraction of the current step.
    assign trial = r_reg + {1'b0, bit_reg};
    assign take  = ({1'b0, rem_reg} >= trial);

    // Step control: run until the lowest bit, then round.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rnd_reg;
            if (start)
            begin
                run_reg <= 1'b1;
                rnd_reg <= 1'b0;
            end
            else if (run_reg && bit_reg[0])
            begin
                run_reg <= 1'b0;
                rnd_reg <= 1'b1;
            end
            else if (rnd_reg)
            begin
                rnd_reg <= 1'b0;
            end
        end
    end

    // Remainder and partial root.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= radicand;
            r_reg   <= '0;
            bit_reg <= SQ_TOP_BIT;
        end
        else if (run_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - trial[SQ_IN_W-1:0];
                r_reg   <= (r_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        // Round to nearest: bump when the remainder exceeds the root.
        if (rnd_reg)
        begin
            root_reg <= r_reg[SQ_OUT_W-1:0] + SQ_OUT_W'({1'b0, rem_reg} > r_reg);
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### sv/ada_cos_div.sv
// ============================================================================
// ada_cos_div
// Restoring divider for the Q30 cosine, clamped to one and rounded.
// ============================================================================
module ada_cos_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ada_pkg::DIV_W-1:0] mag,
    input  logic [ada_pkg::DIV_W-1:0] divisor,
    output logic                     done,
    output logic [ada_pkg::COS_W-1:0] cos_q
);
    import ada_pkg::*;

    logic [DIV_W:0]      rem_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [COS_FRAC-1:0] q_reg;
    logic [4:0]          cnt_reg;
    logic                run_reg;
    logic                rnd_reg;
    logic                done_reg;
    logic [COS_W-1:0]    cos_reg;
    logic [DIV_W+1:0]    shifted;
    logic                fits;
    logic                sat;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = (shifted >= {2'b0, div_reg});
    assign sat     = (mag >= divisor);

    // Control: saturate at once, or run the quotient bits then round.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                rnd_reg <= 1'b0;
                if (sat)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(COS_FRAC - 1))
                begin
                    run_reg <= 1'b0;
                    rnd_reg <= 1'b1;
                end
            end
            else if (rnd_reg)
            begin
                rnd_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Quotient and remainder; the divisor is held for the whole division.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, mag};
            div_reg <= divisor;
            q_reg   <= '0;
            if (sat)
            begin
                cos_reg <= COS_ONE;
            end
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= (DIV_W+1)'(shifted - {2'b0, div_reg});
                q_reg   <= {q_reg[COS_FRAC-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_W:0];
                q_reg   <= {q_reg[COS_FRAC-2:0], 1'b0};
            end
        end
        else if (rnd_reg)
        begin
            cos_reg <= {1'b0, q_reg} + COS_W'(fits);
        end
    end

    assign done  = done_reg;
    assign cos_q = cos_reg;

endmodule

### sv/ada_cordic.sv
// ============================================================================
// ada_cordic
// Vectoring CORDIC for atan2(sin, cos), folded to the bond angle in Q2.16.
// ============================================================================
module ada_cordic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ada_pkg::COS_W-1:0]    cos_in,
    input  logic [ada_pkg::SQ_OUT_W-1:0] sin_in,
    input  logic                        obtuse,
    output logic                        done,
    output logic [ada_pkg::VALUE_W-1:0]  angle
);
    import ada_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic [4:0]                 k_reg;
    logic                       neg_reg;
    logic                       run_reg;
    logic                       fin_reg;
    logic                       done_reg;
    logic [VALUE_W-1:0]         angle_reg;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [Z_W-1:0]      step_ang;
    logic signed [Z_W-1:0]      zf;
    logic signed [Z_W-1:0]      zc;
    logic signed [Z_W-1:0]      zr;

    assign xs       = x_reg >>> k_reg;
    assign ys       = y_reg >>> k_reg;
    assign step_ang = $signed({3'b000, ada_atan(k_reg)});

    // Fold for an obtuse angle, clamp to [0, pi] and round to Q2.16.
    always_comb
    begin
        zf = neg_reg ? (ANGLE_Q24_PI - z_reg) : z_reg;
        zc = zf;
        if (zf < 0)
        begin
            zc = '0;
        end
        else if (zf > ANGLE_Q24_PI)
        begin
            zc = ANGLE_Q24_PI;
        end
        zr = zc + 27'sd128;
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                k_reg   <= '0;
            end
            else if (run_reg)
            begin
                k_reg <= k_reg + 5'd1;
                if (k_reg == 5'(CORDIC_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // Rotation toward the x axis.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= $signed({3'b000, cos_in});
            y_reg   <= $signed({3'b000, sin_in});
            z_reg   <= '0;
            neg_reg <= obtuse;
        end
        else if (run_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_ang;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_ang;
            end
        end
        if (fin_reg)
        begin
            angle_reg <= VALUE_W'(zr[Z_W-1:8]);
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule
